// ===== rtl/sorted_longest_consecutive_run_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted longest consecutive run: assertion macros
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LONGEST_CONSECUTIVE_RUN_DEFINES_SVH
`define SORTED_LONGEST_CONSECUTIVE_RUN_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLCR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcr: assertion failed");
// next-cycle implication
`define SLCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcr: assertion failed");
`else
`define SLCR_ASSERT_IMPLIES(label, ante, cons)
`define SLCR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/slcr_pkg.sv =====
// ----------------------------------------------------------------------------
// slcr_pkg
// Types and constants shared by the sorted longest consecutive run block.
// ----------------------------------------------------------------------------
`default_nettype none

package slcr_pkg;

    localparam int MAX_ITEMS   = 16;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W     = 32;
    localparam int RUN_W       = 5;
    localparam int RUN_MAX     = (2 ** RUN_W) - 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_MANY = 2'd1,
        STATUS_NO_RUN   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FS_COLLECT,
        FS_SORT_OUT,
        FS_ERR_OUT
    } front_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [RUN_W-1:0]          run_length;
        status_t                   status;
        logic                      final_res;
    } out_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_final;
        logic                      is_err;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/slcr_front.sv =====
// ----------------------------------------------------------------------------
// slcr_front
// Insertion cell chain: keeps the set sorted as items arrive, then shifts
// the sorted set (or one error entry) into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_longest_consecutive_run_defines.svh"

module slcr_front
    import slcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          q_push,
    output q_entry_t      q_entry,
    input  wire logic     q_full
);

    front_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic signed [VALUE_W-1:0] cells_reg [MAX_ITEMS];
    logic signed [VALUE_W-1:0] cells_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] greater;
    logic signed [VALUE_W-1:0] in_value;
    logic accept, at_max, last_is_err;

    assign in_value    = item.value;
    assign accept      = push && !full;
    assign at_max      = (count_reg == CNT_W'(MAX_ITEMS));
    assign last_is_err = ovf_reg || at_max;

    // thermometer: cells at or above the insertion point
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            greater[i] = (CNT_W'(i) >= count_reg) || (cells_reg[i] > in_value);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_COLLECT:
            begin
                if (accept && item.last)
                begin
                    state_next = last_is_err ? FS_ERR_OUT : FS_SORT_OUT;
                end
            end
            FS_SORT_OUT:
            begin
                if (!q_full && count_reg == CNT_W'(1))
                begin
                    state_next = FS_COLLECT;
                end
            end
            FS_ERR_OUT:
            begin
                if (!q_full)
                begin
                    state_next = FS_COLLECT;
                end
            end
            default: state_next = FS_COLLECT;
        endcase
    end

    always_comb
    begin
        full             = (state_reg != FS_COLLECT);
        q_push           = 1'b0;
        q_entry.value    = cells_reg[0];
        q_entry.is_final = (count_reg == CNT_W'(1));
        q_entry.is_err   = 1'b0;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        cells_next       = cells_reg;
        unique case (state_reg)
            FS_COLLECT:
            begin
                if (accept)
                begin
                    if (at_max)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (greater[0])
                        begin
                            cells_next[0] = in_value;
                        end
                        for (int i = 1; i < MAX_ITEMS; i++)
                        begin
                            if (greater[i])
                            begin
                                cells_next[i] = greater[i-1] ? cells_reg[i-1] : in_value;
                            end
                        end
                    end
                end
            end
            FS_SORT_OUT:
            begin
                q_push = !q_full;
                if (!q_full)
                begin
                    count_next = count_reg - CNT_W'(1);
                    for (int i = 0; i < MAX_ITEMS - 1; i++)
                    begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
            end
            FS_ERR_OUT:
            begin
                q_push           = !q_full;
                q_entry.value    = '0;
                q_entry.is_final = 1'b1;
                q_entry.is_err   = 1'b1;
                if (!q_full)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_COLLECT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
    end

    `SLCR_ASSERT_IMPLIES(a_count_bound, state_reg == FS_COLLECT, count_reg <= CNT_W'(MAX_ITEMS))
    `SLCR_ASSERT_IMPLIES(a_sort_nonempty, state_reg == FS_SORT_OUT, count_reg != '0)
    `SLCR_ASSERT_IMPLIES(a_err_flagged, state_reg == FS_ERR_OUT, ovf_reg)
    `SLCR_ASSERT_NEXT(a_final_closes, q_push && q_entry.is_final, state_reg == FS_COLLECT)

endmodule

`default_nettype wire

// ===== rtl/slcr_queue.sv =====
// ----------------------------------------------------------------------------
// slcr_queue
// Short register queue between the cell chain and the run tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module slcr_queue
    import slcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire q_entry_t wr_data,
    output logic          full,
    input  wire logic     rd_en,
    output q_entry_t      rd_data,
    output logic          empty
);

    q_entry_t slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic do_wr, do_rd;

    assign full    = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slcr_back.sv =====
// ----------------------------------------------------------------------------
// slcr_back
// Run tracker: walks the sorted stream, keeps current and best run, and
// holds the result register seen on the output side.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_longest_consecutive_run_defines.svh"

module slcr_back
    import slcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_entry_t q_entry,
    input  wire logic     q_empty,
    output logic          q_pop,
    input  wire logic     pop,
    output logic          empty,
    output out_item_t     result
);

    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic first_reg, first_next;
    logic signed [VALUE_W-1:0] prev_reg, prev_next;
    logic [RUN_W-1:0] cur_reg, cur_next;
    logic [RUN_W-1:0] best_reg, best_next;
    logic take, is_step;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign take   = !q_empty && (!out_valid_reg || pop);
    assign q_pop  = take;
    // 33-bit compare: neighbor is exactly one above
    assign is_step = ({prev_reg[VALUE_W-1], prev_reg} + (VALUE_W+1)'(1))
                     == {q_entry.value[VALUE_W-1], q_entry.value};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            prev_next      = q_entry.value;
            if (q_entry.is_err)
            begin
                cur_next  = RUN_W'(1);
                best_next = RUN_W'(1);
            end
            else if (first_reg || !is_step)
            begin
                cur_next  = RUN_W'(1);
                best_next = first_reg ? RUN_W'(1) : best_reg;
            end
            else
            begin
                cur_next  = (cur_reg == RUN_W'(RUN_MAX)) ? cur_reg : cur_reg + RUN_W'(1);
                best_next = (cur_next > best_reg) ? cur_next : best_reg;
            end
            first_next = q_entry.is_final;

            out_next.final_res = q_entry.is_final;
            if (q_entry.is_err)
            begin
                out_next.sorted_value = '0;
                out_next.run_length   = '0;
                out_next.status       = STATUS_TOO_MANY;
            end
            else if (q_entry.is_final)
            begin
                out_next.sorted_value = q_entry.value;
                out_next.run_length   = best_next;
                out_next.status       = (best_next == RUN_W'(1)) ? STATUS_NO_RUN : STATUS_OK;
            end
            else
            begin
                out_next.sorted_value = q_entry.value;
                out_next.run_length   = '0;
                out_next.status       = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
    end

    `SLCR_ASSERT_IMPLIES(a_mid_plain, out_valid_reg && !out_reg.final_res, out_reg.run_length == '0 && out_reg.status == STATUS_OK)
    `SLCR_ASSERT_IMPLIES(a_norun_one, out_valid_reg && out_reg.status == STATUS_NO_RUN, out_reg.run_length == RUN_W'(1) && out_reg.final_res)
    `SLCR_ASSERT_IMPLIES(a_err_zero, out_valid_reg && out_reg.status == STATUS_TOO_MANY, out_reg.sorted_value == '0 && out_reg.run_length == '0)
    `SLCR_ASSERT_NEXT(a_err_resets, take && q_entry.is_err, first_reg)

endmodule

`default_nettype wire

// ===== rtl/sorted_longest_consecutive_run.sv =====
// ----------------------------------------------------------------------------
// sorted_longest_consecutive_run
// Collects a set of signed values, sorts them, emits them ascending and
// reports the longest run of neighbors differing by one on the last result.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// input     push / full        item   (in_item_t: value, last)
// result    pop / empty        result (out_item_t: sorted_value, run_length,
//                                      status, final_res)
//
// Elements enter the insertion cell chain one per cycle while full is low;
// after the last one the chain shifts one sorted element per cycle into the
// queue while the queue has room.
// full stays high while the chain drains; a stalled result side backs up
// through the queue into the drain. Reset (rst_n, async, low) empties all.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_longest_consecutive_run
    import slcr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    input  wire logic     pop,
    output logic          empty,
    output out_item_t     result
);

    logic     fq_push, fq_full, bq_pop, bq_empty;
    q_entry_t fq_entry, bq_entry;

    slcr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (fq_push),
        .q_entry (fq_entry),
        .q_full  (fq_full)
    );

    slcr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_entry),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_data (bq_entry),
        .empty   (bq_empty)
    );

    slcr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (bq_entry),
        .q_empty (bq_empty),
        .q_pop   (bq_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== tb/sorted_longest_consecutive_run_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_longest_consecutive_run_tb
// Sends sets of signed values with a last mark and checks the sorted stream,
// the longest run of neighbors differing by one and the status against a
// scoreboard. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_longest_consecutive_run_tb;
    import slcr_pkg::*;

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 160;

    class run_scoreboard;
        logic signed [VALUE_W-1:0] held[MAX_ITEMS];
        int        held_count = 0;
        bit        dropped    = 1'b0;
        out_item_t expected_q[$];
        int        mismatches    = 0;
        int        sets_closed   = 0;
        int        overflow_sets = 0;
        int        results_seen  = 0;

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(in_item_t x);
            logic signed [VALUE_W-1:0] key;
            longint                    diff;
            int unsigned               cur;
            int unsigned               best;
            int                        i;
            int                        j;
            out_item_t                 e;
            if (held_count < MAX_ITEMS)
            begin
                held[held_count] = x.value;
                held_count++;
            end
            else
                dropped = 1'b1;
            if (!x.last)
                return;
            sets_closed++;
            if (dropped)
            begin
                overflow_sets++;
                e.sorted_value = '0;
                e.run_length   = '0;
                e.status       = STATUS_TOO_MANY;
                e.final_res    = 1'b1;
                expected_q.push_back(e);
            end
            else
            begin
                for (i = 1; i < held_count; i++)
                begin
                    key = held[i];
                    j   = i;
                    while (j > 0 && held[j-1] > key)
                    begin
                        held[j] = held[j-1];
                        j--;
                    end
                    held[j] = key;
                end
                cur  = 1;
                best = 1;
                for (i = 1; i < held_count; i++)
                begin
                    diff = longint'(held[i]) - longint'(held[i-1]);
                    if (diff == 1)
                    begin
                        cur++;
                        if (cur > best)
                            best = cur;
                    end
                    else
                        cur = 1;
                end
                if (best > RUN_MAX)
                    best = RUN_MAX;
                for (i = 0; i < held_count; i++)
                begin
                    e.sorted_value = held[i];
                    e.run_length   = '0;
                    e.status       = STATUS_OK;
                    e.final_res    = 1'b0;
                    if (i == held_count - 1)
                    begin
                        e.run_length = best[RUN_W-1:0];
                        e.status     = (best == 1) ? STATUS_NO_RUN : STATUS_OK;
                        e.final_res  = 1'b1;
                    end
                    expected_q.push_back(e);
                end
            end
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: sorted_value %0d", r.sorted_value);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (r.sorted_value !== e.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", e.sorted_value, r.sorted_value);
                mismatches++;
            end
            if (r.run_length !== e.run_length)
            begin
                $error("run_length: expected %0d, got %0d", e.run_length, r.run_length);
                mismatches++;
            end
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, r.status);
                mismatches++;
            end
            if (r.final_res !== e.final_res)
            begin
                $error("final_res: expected %0d, got %0d", e.final_res, r.final_res);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  item  = '0;
    logic      pop   = 1'b0;
    logic      empty;
    out_item_t result;

    run_scoreboard sb = new();

    logic signed [VALUE_W-1:0] set_vals[$];
    int items_sent = 0;
    int burst_left = 0;
    int pop_mode   = 0;
    int pop_cycle  = 0;

    sorted_longest_consecutive_run i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: stall pattern picked at random from four modes
    always @(negedge clk)
    begin
        if (pop_cycle % 50 == 0)
            pop_mode = $urandom_range(0, 3);
        pop_cycle++;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= pop_cycle[3];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input in_item_t x);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        push = 1'b1;
        item = x;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_input(x);
        items_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic send_set();
        in_item_t x;
        int       i;
        for (i = 0; i < set_vals.size(); i++)
        begin
            x.value = set_vals[i];
            x.last  = (i == set_vals.size() - 1);
            send_item(x);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic build_random_set(input int n);
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] t;
        int                        flavor;
        int                        i;
        int                        j;
        flavor = $urandom_range(0, 3);
        base   = $urandom;
        set_vals.delete();
        for (i = 0; i < n; i++)
        begin
            case (flavor)
                0: v = $urandom;
                1:
                begin
                    v = base + i;
                    if (i > 0 && $urandom_range(0, 7) == 0)
                        v = base + i - 1;
                end
                2: v = $signed($urandom_range(0, 24)) - 12;
                default:
                begin
                    v = $urandom_range(0, 6);
                    v = $urandom_range(0, 1) ? VMAX - v : VMIN + v;
                end
            endcase
            set_vals.push_back(v);
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = set_vals[i];
            set_vals[i] = set_vals[j];
            set_vals[j] = t;
        end
    endtask

    initial
    begin
        int first_random;
        int k;
        bit paused;
        paused = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed sets: single extremes, wrap pair, mixed extremes,
        // duplicate inside a run, plain run, no run
        set_vals = {VMAX};
        send_set();
        set_vals = {VMIN};
        send_set();
        set_vals = {VMAX, VMIN};
        send_set();
        set_vals = {VMAX, 32'sd0, VMIN + 1, -32'sd1, VMAX - 1, VMIN};
        send_set();
        set_vals = {32'sd6, 32'sd5, 32'sd4, 32'sd5};
        send_set();
        set_vals = {32'sd3, 32'sd1, 32'sd2};
        send_set();
        set_vals = {-32'sd7, 32'sd9, 32'sd100};
        send_set();
        wait_drained();

        // random: one full chain of a single run, one overflow, then a mix
        first_random = items_sent;
        set_vals.delete();
        for (k = 0; k < MAX_ITEMS; k++)
            set_vals.push_back(32'sd1000 + MAX_ITEMS - 1 - k);
        send_set();
        build_random_set(MAX_ITEMS + 1);
        send_set();
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            k = $urandom_range(0, 19);
            if (k < 14)
                build_random_set($urandom_range(1, 8));
            else if (k < 17)
                build_random_set(MAX_ITEMS);
            else if (k < 18)
                build_random_set($urandom_range(9, MAX_ITEMS - 1));
            else
                build_random_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4));
            send_set();
            if (!paused && items_sent - first_random >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (4 * MAX_ITEMS) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("run covered %0d input transfers in %0d sets (%0d overflowed)",
                 items_sent, sb.sets_closed, sb.overflow_sets);
        $display("and %0d result transfers checked", sb.results_seen);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
